/* design/erm_pkg.sv */
// erm_pkg: shared types and constants of the ultrasonic echo range meter
// holds configuration register indexes, reset values, status codes and the divider status type
// no dependencies

package erm_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_TRIGGER_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_COUNTS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM      = 3'd4;

    // configuration reset values (prescaler 1024 at 16 MHz, 58 us per cm)
    localparam logic [15:0] RST_TICKS_PER_COUNT   = 16'd64;
    localparam logic [7:0]  RST_PRE_TRIGGER_TICKS = 8'd1;
    localparam logic [7:0]  RST_TRIGGER_TICKS     = 8'd10;
    localparam logic [15:0] RST_TIMEOUT_COUNTS    = 16'd65000;
    localparam logic [7:0]  RST_TICKS_PER_CM      = 8'd58;

    // measurement status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_ECHO   = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;
    localparam logic [1:0] STATUS_SATURATED = 2'd3;

    // divider status back to the sequencer
    typedef struct packed {
        logic done;
        logic sat;
    } div_stat_t;

endpackage

/* design/erm_div.sv */
// erm_div: distance unit, one multiply then a bit-serial restoring divide
// computes floor(count * ticks_per_count / ticks_per_cm) with saturation detect
// depends on erm_pkg

module erm_div #(
    parameter int COUNT_WIDTH    = 16,
    parameter int DISTANCE_WIDTH = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [COUNT_WIDTH-1:0]    count,
    input  logic [15:0]               ticks_per_count,
    input  logic [7:0]                ticks_per_cm,
    output erm_pkg::div_stat_t        stat,
    output logic [DISTANCE_WIDTH-1:0] quotient
);

    localparam int PROD_W = COUNT_WIDTH + 16;
    localparam int HI_W   = PROD_W - DISTANCE_WIDTH;
    localparam int STEP_W = $clog2(DISTANCE_WIDTH + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_CMP  = 2'd2;
    localparam logic [1:0] D_RUN  = 2'd3;

    logic [1:0]                dstate_reg;
    logic [COUNT_WIDTH-1:0]    opnd_reg;
    logic [15:0]               mul_reg;
    logic [7:0]                div_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [7:0]                rem_reg;
    logic [DISTANCE_WIDTH-1:0] low_reg;
    logic [DISTANCE_WIDTH-1:0] quot_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      done_reg;
    logic                      sat_reg;

    logic [PROD_W-1:0] prod_full;
    logic [HI_W-1:0]   prod_hi;
    logic [8:0]        trial;
    logic [8:0]        trial_diff;
    logic              trial_ge;

    // product and the part of it above the quotient bits
    assign prod_full = opnd_reg * mul_reg;
    assign prod_hi   = prod_reg[PROD_W-1:DISTANCE_WIDTH];

    // one restoring step: bring down the next product bit
    assign trial      = {rem_reg, low_reg[DISTANCE_WIDTH-1]};
    assign trial_ge   = trial >= {1'b0, div_reg};
    assign trial_diff = trial - {1'b0, div_reg};

    // sequencer of the divide unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstate_reg <= D_IDLE;
            done_reg   <= 1'b0;
            sat_reg    <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (dstate_reg)
                D_IDLE: begin
                    if (start) begin
                        opnd_reg   <= count;
                        mul_reg    <= (ticks_per_count == 16'd0) ? 16'd1 : ticks_per_count;
                        div_reg    <= (ticks_per_cm == 8'd0) ? 8'd1 : ticks_per_cm;
                        dstate_reg <= D_MUL;
                    end
                end
                D_MUL: begin
                    prod_reg   <= prod_full;
                    dstate_reg <= D_CMP;
                end
                D_CMP: begin
                    // quotient overflows the distance range iff the high part reaches the divisor
                    if (prod_hi >= HI_W'(div_reg)) begin
                        sat_reg    <= 1'b1;
                        done_reg   <= 1'b1;
                        dstate_reg <= D_IDLE;
                    end else begin
                        sat_reg    <= 1'b0;
                        rem_reg    <= prod_hi[7:0];
                        low_reg    <= prod_reg[DISTANCE_WIDTH-1:0];
                        step_reg   <= STEP_W'(DISTANCE_WIDTH);
                        dstate_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    rem_reg  <= trial_ge ? trial_diff[7:0] : trial[7:0];
                    quot_reg <= {quot_reg[DISTANCE_WIDTH-2:0], trial_ge};
                    low_reg  <= {low_reg[DISTANCE_WIDTH-2:0], 1'b0};
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == STEP_W'(1)) begin
                        done_reg   <= 1'b1;
                        dstate_reg <= D_IDLE;
                    end
                end
            endcase
        end
    end

    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign quotient  = quot_reg;

endmodule

/* design/ultrasonic_echo_range_meter.sv */
// ultrasonic_echo_range_meter: trigger pulse, echo timing and distance, one result per tick
// order: each tick is registered, stepped and its result pushed; the falling-echo tick also waits for the divider
// flow: a new tick is taken only after the last tick's result is pushed (bit-serial divider)
// reset: synchronous, active low; idle phase, counters and last result cleared, registers to defaults
// depends on erm_pkg and erm_div

module ultrasonic_echo_range_meter #(
    parameter int COUNT_WIDTH    = 16,
    parameter int DISTANCE_WIDTH = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tick input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_start_req,
    input  logic                               s_echo_level,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_trigger_level,
    output logic                               m_busy_res,
    output logic                               m_done_res,
    output logic [DISTANCE_WIDTH-1:0]          m_distance_cm,
    output logic [1:0]                         m_status,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [erm_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [erm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // measurement phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_GAP   = 3'd1;
    localparam logic [2:0] PH_PULSE = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_ECHO  = 3'd4;

    // sequencer states
    localparam logic [1:0] SQ_IN   = 2'd0;
    localparam logic [1:0] SQ_EXEC = 2'd1;
    localparam logic [1:0] SQ_DIV  = 2'd2;
    localparam logic [1:0] SQ_PUSH = 2'd3;

    // configuration
    logic [15:0] tpc_reg;
    logic [7:0]  pre_reg;
    logic [7:0]  trig_len_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  cm_reg;

    // measurement state
    logic [1:0]                sq_reg;
    logic                      start_reg;
    logic                      echo_reg;
    logic [2:0]                phase_reg;
    logic [15:0]               tick_reg;
    logic [COUNT_WIDTH-1:0]    timer_reg;
    logic [DISTANCE_WIDTH-1:0] last_dist_reg;
    logic [1:0]                last_status_reg;
    logic                      res_trig_reg;
    logic                      res_done_reg;

    // output register
    logic                      m_valid_reg;
    logic                      m_trig_reg;
    logic                      m_busy_reg;
    logic                      m_done_reg;
    logic [DISTANCE_WIDTH-1:0] m_dist_reg;
    logic [1:0]                m_status_reg;

    // next values of one tick
    logic [2:0]             phase_next;
    logic [15:0]            tick_next;
    logic [COUNT_WIDTH-1:0] timer_next;
    logic                   trig_next;
    logic                   done_next;
    logic                   fin_next;
    logic [1:0]             fin_status_next;
    logic                   div_go;

    // timer advance
    logic                   wait_rise;
    logic [15:0]            tick_inc;
    logic [15:0]            adv_base_tick;
    logic [COUNT_WIDTH-1:0] adv_base_timer;
    logic [15:0]            adv_tc;
    logic                   adv_wrap;
    logic [15:0]            adv_tick;
    logic [COUNT_WIDTH-1:0] adv_timer;
    logic                   timed_out;

    erm_pkg::div_stat_t        div_stat;
    logic [DISTANCE_WIDTH-1:0] div_quot;
    logic                      push;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpc_reg      <= erm_pkg::RST_TICKS_PER_COUNT;
            pre_reg      <= erm_pkg::RST_PRE_TRIGGER_TICKS;
            trig_len_reg <= erm_pkg::RST_TRIGGER_TICKS;
            timeout_reg  <= erm_pkg::RST_TIMEOUT_COUNTS;
            cm_reg       <= erm_pkg::RST_TICKS_PER_CM;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                erm_pkg::CFG_TICKS_PER_COUNT:   tpc_reg      <= cfg_wdata;
                erm_pkg::CFG_PRE_TRIGGER_TICKS: pre_reg      <= cfg_wdata[7:0];
                erm_pkg::CFG_TRIGGER_TICKS:     trig_len_reg <= cfg_wdata[7:0];
                erm_pkg::CFG_TIMEOUT_COUNTS:    timeout_reg  <= cfg_wdata;
                erm_pkg::CFG_TICKS_PER_CM:      cm_reg       <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // prescaled timer advance; echo rising in wait restarts both counts
    assign wait_rise      = (phase_reg == PH_WAIT) && echo_reg;
    assign tick_inc       = tick_reg + 16'd1;
    assign adv_base_tick  = wait_rise ? 16'd0 : tick_reg;
    assign adv_base_timer = wait_rise ? '0 : timer_reg;
    assign adv_tc         = adv_base_tick + 16'd1;
    assign adv_wrap       = (adv_tc >= tpc_reg) || (adv_tc == 16'd0);
    assign adv_tick       = adv_wrap ? 16'd0 : adv_tc;
    assign adv_timer      = (adv_wrap && (adv_base_timer != COUNT_MAX))
                            ? adv_base_timer + COUNT_WIDTH'(1) : adv_base_timer;
    assign timed_out      = CMP_W'(adv_timer) > CMP_W'(timeout_reg);

    // phase logic of one tick
    always_comb begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        timer_next      = timer_reg;
        trig_next       = 1'b0;
        done_next       = 1'b0;
        fin_next        = 1'b0;
        fin_status_next = erm_pkg::STATUS_OK;
        div_go          = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start_reg) begin
                    tick_next  = 16'd0;
                    phase_next = (pre_reg != 8'd0) ? PH_GAP : PH_PULSE;
                end
            end
            PH_GAP: begin
                tick_next = tick_inc;
                if (tick_inc >= {8'd0, pre_reg}) begin
                    tick_next  = 16'd0;
                    phase_next = PH_PULSE;
                end
            end
            PH_PULSE: begin
                trig_next = 1'b1;
                tick_next = tick_inc;
                if (tick_inc >= {8'd0, trig_len_reg}) begin
                    tick_next  = 16'd0;
                    timer_next = '0;
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT: begin
                tick_next  = adv_tick;
                timer_next = adv_timer;
                if (echo_reg) begin
                    phase_next = PH_ECHO;
                end
                if (timed_out) begin
                    fin_next        = 1'b1;
                    done_next       = 1'b1;
                    phase_next      = PH_IDLE;
                    fin_status_next = echo_reg ? erm_pkg::STATUS_TOO_LONG
                                               : erm_pkg::STATUS_NO_ECHO;
                end
            end
            PH_ECHO: begin
                if (echo_reg) begin
                    tick_next  = adv_tick;
                    timer_next = adv_timer;
                    if (timed_out) begin
                        fin_next        = 1'b1;
                        done_next       = 1'b1;
                        phase_next      = PH_IDLE;
                        fin_status_next = erm_pkg::STATUS_TOO_LONG;
                    end
                end else begin
                    // echo fell: distance comes from the divider
                    div_go = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    erm_div #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .DISTANCE_WIDTH (DISTANCE_WIDTH)
    ) u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           ((sq_reg == SQ_EXEC) && div_go),
        .count           (timer_reg),
        .ticks_per_count (tpc_reg),
        .ticks_per_cm    (cm_reg),
        .stat            (div_stat),
        .quotient        (div_quot)
    );

    assign push = (sq_reg == SQ_PUSH) && (!m_valid_reg || m_ready);

    // tick sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg          <= SQ_IN;
            phase_reg       <= PH_IDLE;
            tick_reg        <= 16'd0;
            timer_reg       <= '0;
            last_dist_reg   <= '0;
            last_status_reg <= erm_pkg::STATUS_OK;
        end else begin
            unique case (sq_reg)
                SQ_IN: begin
                    if (s_valid) begin
                        start_reg <= s_start_req;
                        echo_reg  <= s_echo_level;
                        sq_reg    <= SQ_EXEC;
                    end
                end
                SQ_EXEC: begin
                    phase_reg    <= phase_next;
                    tick_reg     <= tick_next;
                    timer_reg    <= timer_next;
                    res_trig_reg <= trig_next;
                    res_done_reg <= done_next;
                    if (fin_next) begin
                        last_dist_reg   <= '0;
                        last_status_reg <= fin_status_next;
                    end
                    sq_reg <= div_go ? SQ_DIV : SQ_PUSH;
                end
                SQ_DIV: begin
                    if (div_stat.done) begin
                        last_dist_reg   <= div_stat.sat ? {DISTANCE_WIDTH{1'b1}} : div_quot;
                        last_status_reg <= div_stat.sat ? erm_pkg::STATUS_SATURATED
                                                        : erm_pkg::STATUS_OK;
                        phase_reg       <= PH_IDLE;
                        res_trig_reg    <= 1'b0;
                        res_done_reg    <= 1'b1;
                        sq_reg          <= SQ_PUSH;
                    end
                end
                SQ_PUSH: begin
                    if (push) begin
                        sq_reg <= SQ_IN;
                    end
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_trig_reg   <= res_trig_reg;
            m_busy_reg   <= (phase_reg != PH_IDLE);
            m_done_reg   <= res_done_reg;
            m_dist_reg   <= last_dist_reg;
            m_status_reg <= last_status_reg;
        end
    end

    assign s_ready         = (sq_reg == SQ_IN);
    assign m_valid         = m_valid_reg;
    assign m_trigger_level = m_trig_reg;
    assign m_busy_res      = m_busy_reg;
    assign m_done_res      = m_done_reg;
    assign m_distance_cm   = m_dist_reg;
    assign m_status        = m_status_reg;

endmodule

/* design/erm_chk.sv */
// erm_chk: port-level checks of the ultrasonic echo range meter and its bind
// watches the result channel only
// depends on erm_pkg and ultrasonic_echo_range_meter

module erm_chk #(
    parameter int DISTANCE_WIDTH = 8
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_trigger_level,
    input logic                      m_busy_res,
    input logic                      m_done_res,
    input logic [DISTANCE_WIDTH-1:0] m_distance_cm,
    input logic [1:0]                m_status
);

    // a finished measurement leaves the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done transaction reports busy");

    // trigger is only driven during a measurement
    a_trig_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_trigger_level |-> m_busy_res && !m_done_res)
        else $error("trigger driven outside a measurement");

    // timeouts report zero distance
    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == erm_pkg::STATUS_NO_ECHO ||
                    m_status == erm_pkg::STATUS_TOO_LONG) |-> m_distance_cm == '0)
        else $error("timeout status with nonzero distance");

    // saturation reports full-scale distance
    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == erm_pkg::STATUS_SATURATED |-> &m_distance_cm)
        else $error("saturated status without full-scale distance");

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance_cm) && $stable(m_status))
        else $error("stalled result transaction changed");

endmodule

bind ultrasonic_echo_range_meter erm_chk #(
    .DISTANCE_WIDTH (DISTANCE_WIDTH)
) u_erm_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_trigger_level (m_trigger_level),
    .m_busy_res      (m_busy_res),
    .m_done_res      (m_done_res),
    .m_distance_cm   (m_distance_cm),
    .m_status        (m_status)
);
